FILE: hw/rtl/rqms_pkg.sv
// ----------------------------------------------------------------------------
// rqms_pkg : shared types and constants of the ready queue
// Queue depth, index widths, payload structs, action and status codes, and
// the logical-to-physical slot mapping of the circular buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package rqms_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OCC_W   = 5;

    localparam logic [2:0] ACT_PUSH      = 3'd0;
    localparam logic [2:0] ACT_POP       = 3'd1;
    localparam logic [2:0] ACT_REMOVE    = 3'd2;
    localparam logic [2:0] ACT_PICK_TIME = 3'd3;
    localparam logic [2:0] ACT_PICK_PRI  = 3'd4;
    localparam logic [2:0] ACT_CLEAR     = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  task_id;
        logic [15:0] time_left;
        logic [7:0]  priority_req;
    } rqms_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             out_valid;
        logic [7:0]       out_task_id;
        logic [OCC_W-1:0] occupancy;
    } rqms_out_t;

    // One stored queue entry, as kept in the slot memory.
    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] slot_time;
        logic [7:0]  slot_priority;
    } rqms_entry_t;

    localparam int ENTRY_W = $bits(rqms_entry_t);

    typedef enum logic [1:0] {
        MODE_ID   = 2'd0,
        MODE_TIME = 2'd1,
        MODE_PRI  = 2'd2
    } rqms_mode_t;

    typedef struct packed {
        logic             clear;
        logic             beat;
        rqms_mode_t       mode;
        logic [7:0]       match_id;
        logic [CNT_W-1:0] pos;
    } rqms_scan_ctl_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] pos;
        logic [7:0]       task_id;
    } rqms_scan_res_t;

    // Physical slot of a logical position. Both operands stay below DEPTH,
    // so one conditional subtract does the wrap.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = (IDX_W + 1)'(head) + (IDX_W + 1)'(pos);
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rqms_ram.sv
// ----------------------------------------------------------------------------
// rqms_ram : generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rqms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rqms_scan.sv
// ----------------------------------------------------------------------------
// rqms_scan : selection unit of the ready queue
// Watches the entries read in queue order and keeps the chosen one: the
// oldest entry with a matching id, or the oldest with the smallest key.
// ----------------------------------------------------------------------------
`default_nettype none

module rqms_scan (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire rqms_pkg::rqms_scan_ctl_t ctl,
    input  wire rqms_pkg::rqms_entry_t   entry,
    output rqms_pkg::rqms_scan_res_t     res
);

    import rqms_pkg::*;

    logic             found_reg, found_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [7:0]       id_reg, id_next;
    logic [15:0]      time_reg, time_next;
    logic [7:0]       pri_reg, pri_next;
    logic             take;

    always_comb
    begin
        case (ctl.mode)
            MODE_ID:   take = !found_reg && (entry.task_id == ctl.match_id);
            MODE_TIME: take = !found_reg || (entry.slot_time < time_reg);
            MODE_PRI:  take = !found_reg || (entry.slot_priority < pri_reg);
            default:   take = 1'b0;
        endcase
    end

    always_comb
    begin
        found_next = found_reg;
        pos_next   = pos_reg;
        id_next    = id_reg;
        time_next  = time_reg;
        pri_next   = pri_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctl.beat && take)
        begin
            found_next = 1'b1;
            pos_next   = ctl.pos;
            id_next    = entry.task_id;
            time_next  = entry.slot_time;
            pri_next   = entry.slot_priority;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        id_reg   <= id_next;
        time_reg <= time_next;
        pri_reg  <= pri_next;
    end

    assign res.found   = found_reg;
    assign res.pos     = pos_reg;
    assign res.task_id = id_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ready_queue_with_min_select_core.sv
// ----------------------------------------------------------------------------
// ready_queue_with_min_select_core : ordered task ready queue
// Circular queue of task entries in one slot RAM, with push, pop, remove by
// id, pick of smallest remaining time or priority number, and clear.
// ----------------------------------------------------------------------------
// A command transfer happens at a rising edge with start high and busy low;
// its single result is shown on rsp for exactly one cycle with done high and
// cannot be held off by the receiver. Push, clear and the unused action codes
// answer straight from the idle state; pop passes through S_POP, since the
// head id comes from the registered read of the slot RAM. Remove and both
// picks read every live entry once in queue order (S_SCAN), settle the
// choice in S_SCAN_END and S_DECIDE, then close the gap by moving each
// younger entry one place forward through the single RAM read and write port
// (S_SHIFT, then S_SHIFT_END to drain). busy stays high for the whole of that
// sequence.
`default_nettype none

module ready_queue_with_min_select_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rqms_pkg::rqms_in_t cmd,
    output logic               done,
    output rqms_pkg::rqms_out_t rsp
);

    import rqms_pkg::*;

    // Sequencer states: the scan and shift phases each keep one RAM read in
    // flight, so each has a trailing state that consumes the last read.
    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_POP       = 7'b0000010,
        S_SCAN      = 7'b0000100,
        S_SCAN_END  = 7'b0001000,
        S_DECIDE    = 7'b0010000,
        S_SHIFT     = 7'b0100000,
        S_SHIFT_END = 7'b1000000
    } rqms_state_t;

    rqms_state_t      state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] pend_pos_reg, pend_pos_next;
    rqms_mode_t       mode_reg, mode_next;
    logic [7:0]       match_id_reg, match_id_next;
    logic             done_reg, done_next;
    rqms_out_t        rsp_reg, rsp_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    rqms_entry_t      ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    rqms_entry_t      ram_rdata;

    rqms_scan_ctl_t   scan_ctl;
    rqms_scan_res_t   scan_res;

    logic             accept;
    logic [CNT_W-1:0] last_pos;
    logic [CNT_W-1:0] count_dec;

    function automatic rqms_out_t make_rsp(input logic [1:0]       status,
                                           input logic             valid,
                                           input logic [7:0]       id,
                                           input logic [CNT_W-1:0] count);
        rqms_out_t r;
        r.status      = status;
        r.out_valid   = valid;
        r.out_task_id = id;
        r.occupancy   = OCC_W'(count);
        return r;
    endfunction

    assign accept    = start && (state_reg == S_IDLE);
    assign last_pos  = count_reg - CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        pend_next     = 1'b0;
        pend_pos_next = pos_reg;
        mode_next     = mode_reg;
        match_id_next = match_id_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;

        ram_we    = 1'b0;
        ram_waddr = phys(head_reg, count_reg);
        ram_wdata.task_id       = cmd.task_id;
        ram_wdata.slot_time     = cmd.time_left;
        ram_wdata.slot_priority = cmd.priority_req;
        ram_re    = 1'b0;
        ram_raddr = phys(head_reg, pos_reg);

        scan_ctl.clear    = 1'b0;
        scan_ctl.beat     = 1'b0;
        scan_ctl.mode     = mode_reg;
        scan_ctl.match_id = match_id_reg;
        scan_ctl.pos      = pend_pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.action)
                        ACT_PUSH:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                rsp_next = make_rsp(ST_FULL, 1'b0, 8'd0, count_reg);
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                rsp_next   = make_rsp(ST_OK, 1'b0, 8'd0, count_next);
                            end
                        end
                        ACT_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(ST_EMPTY, 1'b0, 8'd0, count_reg);
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                state_next = S_POP;
                            end
                        end
                        ACT_REMOVE, ACT_PICK_TIME, ACT_PICK_PRI:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(ST_EMPTY, 1'b0, 8'd0, count_reg);
                            end
                            else
                            begin
                                scan_ctl.clear = 1'b1;
                                if (cmd.action == ACT_REMOVE)
                                begin
                                    mode_next = MODE_ID;
                                end
                                else if (cmd.action == ACT_PICK_TIME)
                                begin
                                    mode_next = MODE_TIME;
                                end
                                else
                                begin
                                    mode_next = MODE_PRI;
                                end
                                match_id_next = cmd.task_id;
                                pos_next      = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                            done_next  = 1'b1;
                            rsp_next   = make_rsp(ST_OK, 1'b0, 8'd0, '0);
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = make_rsp(ST_OK, 1'b0, 8'd0, count_reg);
                        end
                    endcase
                end
            end
            S_POP:
            begin
                head_next  = phys(head_reg, CNT_W'(1));
                count_next = count_dec;
                done_next  = 1'b1;
                rsp_next   = make_rsp(ST_OK, 1'b1, ram_rdata.task_id, count_dec);
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // Issue the read of one entry; the entry read last cycle is
                // handed to the selection unit.
                ram_re        = 1'b1;
                pend_next     = 1'b1;
                pend_pos_next = pos_reg;
                pos_next      = pos_reg + CNT_W'(1);
                scan_ctl.beat = pend_reg;
                if (pos_reg == last_pos)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                scan_ctl.beat = pend_reg;
                state_next    = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!scan_res.found)
                begin
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(ST_NOT_FOUND, 1'b0, 8'd0, count_reg);
                    state_next = S_IDLE;
                end
                else if (scan_res.pos == last_pos)
                begin
                    // The youngest entry goes: nothing behind it to move.
                    count_next = count_dec;
                    done_next  = 1'b1;
                    rsp_next   = make_rsp(ST_OK, 1'b1, scan_res.task_id, count_dec);
                    state_next = S_IDLE;
                end
                else
                begin
                    pos_next   = scan_res.pos + CNT_W'(1);
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // Read position p while writing the entry read last cycle
                // (position p - 1) to position p - 2; the two slots are never
                // the same.
                ram_re        = 1'b1;
                pend_next     = 1'b1;
                pend_pos_next = pos_reg;
                pos_next      = pos_reg + CNT_W'(1);
                ram_we        = pend_reg;
                ram_waddr     = phys(head_reg, pend_pos_reg - CNT_W'(1));
                ram_wdata     = ram_rdata;
                if (pos_reg == last_pos)
                begin
                    state_next = S_SHIFT_END;
                end
            end
            S_SHIFT_END:
            begin
                ram_we     = pend_reg;
                ram_waddr  = phys(head_reg, pend_pos_reg - CNT_W'(1));
                ram_wdata  = ram_rdata;
                count_next = count_dec;
                done_next  = 1'b1;
                rsp_next   = make_rsp(ST_OK, 1'b1, scan_res.task_id, count_dec);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        pend_pos_reg <= pend_pos_next;
        mode_reg     <= mode_next;
        match_id_reg <= match_id_next;
        rsp_reg      <= rsp_next;
    end

    rqms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rqms_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .entry (ram_rdata),
        .res   (scan_res)
    );

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rqms_checker.sv
// ----------------------------------------------------------------------------
// rqms_checker : port-level checks of the ready queue
// Watches the command and result ports and flags results that break the
// sequencing or status rules of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rqms_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire rqms_pkg::rqms_out_t rsp
);

    import rqms_pkg::*;

    // A result transfer ends the command, so the block is free again.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while the queue is still busy");

    // Every accepted command either starts a sequence or answers at once.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither busy nor answered");

    // Only a successful removal carries a task id.
    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.out_valid) |-> (rsp.status == ST_OK))
        else $error("removed entry reported with an error status");

    // A full report comes only with a full queue.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == ST_FULL)) |-> (rsp.occupancy == OCC_W'(DEPTH)))
        else $error("full status with a queue that is not full");

    // An empty report comes only with an empty queue.
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == ST_EMPTY)) |-> (rsp.occupancy == '0))
        else $error("empty status with a queue that holds entries");

endmodule

bind ready_queue_with_min_select_core rqms_checker u_rqms_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

FILE: sim/ready_queue_checker.sv
// ----------------------------------------------------------------------------
// ready_queue_checker : response checker for the ready queue core
// Watches the command and response channels, keeps a shadow copy of the
// queue in logical order, and compares every response field by field with
// the oldest expected response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ready_queue_checker
    import rqms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  rqms_in_t  cmd,
    input  logic      done,
    input  rqms_out_t rsp,
    output int        error_count,
    output int        outstanding
);

    // Live entries, oldest first. Slots outside the live range are never
    // read by the core, so the circular buffer itself need not be mirrored.
    rqms_entry_t shadow_queue[$];
    rqms_out_t   expected_rsp[$];
    int          mismatches = 0;
    int          pending = 0;

    assign error_count = mismatches;
    assign outstanding = pending;

    // Applies one command to the shadow queue and returns its response.
    function automatic rqms_out_t apply_command(input rqms_in_t c);
        rqms_out_t r;
        int        best;
        int        i;
        bit        smaller;
        r = '0;
        case (c.action)
            ACT_PUSH:
            begin
                if (shadow_queue.size() >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    shadow_queue.push_back('{c.task_id, c.time_left, c.priority_req});
                end
            end
            ACT_POP:
            begin
                if (shadow_queue.size() == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.out_valid   = 1'b1;
                    r.out_task_id = shadow_queue[0].task_id;
                    shadow_queue.delete(0);
                end
            end
            ACT_REMOVE:
            begin
                if (shadow_queue.size() == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.status = ST_NOT_FOUND;
                    for (i = 0; i < shadow_queue.size(); i++)
                    begin
                        if (shadow_queue[i].task_id == c.task_id)
                        begin
                            r.status      = ST_OK;
                            r.out_valid   = 1'b1;
                            r.out_task_id = shadow_queue[i].task_id;
                            shadow_queue.delete(i);
                            break;
                        end
                    end
                end
            end
            ACT_PICK_TIME, ACT_PICK_PRI:
            begin
                if (shadow_queue.size() == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    // Strict compare, so a tie keeps the older entry.
                    best = 0;
                    for (i = 1; i < shadow_queue.size(); i++)
                    begin
                        if (c.action == ACT_PICK_TIME)
                        begin
                            smaller = shadow_queue[i].slot_time < shadow_queue[best].slot_time;
                        end
                        else
                        begin
                            smaller = shadow_queue[i].slot_priority
                                      < shadow_queue[best].slot_priority;
                        end
                        if (smaller)
                        begin
                            best = i;
                        end
                    end
                    r.out_valid   = 1'b1;
                    r.out_task_id = shadow_queue[best].task_id;
                    shadow_queue.delete(best);
                end
            end
            ACT_CLEAR:
            begin
                shadow_queue.delete();
            end
            default:
            begin
            end
        endcase
        r.occupancy = OCC_W'(shadow_queue.size());
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    // The response is checked before a command taken at the same edge is
    // predicted, since that response always belongs to an older command.
    always @(posedge clk)
    begin
        rqms_out_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (expected_rsp.size() == 0)
                begin
                    note_mismatch("response count (none pending)", 16'd0, 16'd1);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        note_mismatch("status", 16'(want.status), 16'(rsp.status));
                    end
                    if (rsp.out_valid !== want.out_valid)
                    begin
                        note_mismatch("out_valid", 16'(want.out_valid), 16'(rsp.out_valid));
                    end
                    if (rsp.out_task_id !== want.out_task_id)
                    begin
                        note_mismatch("out_task_id", 16'(want.out_task_id),
                                      16'(rsp.out_task_id));
                    end
                    if (rsp.occupancy !== want.occupancy)
                    begin
                        note_mismatch("occupancy", 16'(want.occupancy), 16'(rsp.occupancy));
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                expected_rsp.push_back(apply_command(cmd));
            end
            pending = expected_rsp.size();
        end
    end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench : top level of the ready queue simulation
// Drives command transfers into the core, first a short directed sequence of
// corner cases and then randomized traffic in several idling phases, while a
// checker beside the core predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import rqms_pkg::*;

    // The two action codes the core does not use; they must answer OK and
    // leave the queue untouched.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    // Random traffic comes in segments with different push weights, so the
    // queue repeatedly fills up to full and drains down to empty.
    localparam int SEGMENT_LEN    = 30;
    localparam int PHASE_ITEMS    = 375;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 50;

    // Sender idle percentage per phase. The receiver cannot stall the core,
    // so the receiver phase runs without idling and the combined phase
    // keeps only the sender part.
    localparam int PHASE_IDLE [4] = '{0, 62, 0, 16};
    localparam int PUSH_WEIGHT [3] = '{85, 50, 20};

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      done;
    rqms_in_t  cmd;
    rqms_out_t rsp;
    int        error_count;
    int        outstanding;
    int        idle_pct = 0;
    int        stall_cycles = 0;

    ready_queue_with_min_select_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    ready_queue_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .rsp         (rsp),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any command or response transfer restarts the count. A long
    // stretch with neither means the core has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic rqms_in_t make_cmd(input logic [2:0] act, input logic [7:0] id,
                                          input logic [15:0] run_time,
                                          input logic [7:0] prio);
        rqms_in_t c;
        c.action       = act;
        c.task_id      = id;
        c.time_left    = run_time;
        c.priority_req = prio;
        return c;
    endfunction

    // Random command. Ids come mostly from a small pool so that removes hit
    // and duplicates occur; times and priorities come mostly from a narrow
    // range so that ties are common, and now and then from the full range.
    function automatic rqms_in_t random_cmd(input int push_pct);
        rqms_in_t c;
        int       roll;
        c.task_id      = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        c.time_left    = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        c.priority_req = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
        begin
            c.action = ACT_PUSH;
        end
        else if (roll < 98)
        begin
            case ($urandom_range(0, 3))
                0:       c.action = ACT_POP;
                1:       c.action = ACT_REMOVE;
                2:       c.action = ACT_PICK_TIME;
                default: c.action = ACT_PICK_PRI;
            endcase
        end
        else if (roll == 98)
        begin
            c.action = ACT_CLEAR;
        end
        else
        begin
            c.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
        end
        return c;
    endfunction

    // One command transfer. Idle cycles are drawn first, which also places
    // gaps while the core is still busy with the previous command. The task
    // returns at the edge where the transfer happens; start then stays high
    // into the next call unless an idle cycle lowers it.
    task automatic send(input rqms_in_t c);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
    endtask

    // Hold the sender off until every expected response has come back.
    // Sampled at falling edges, where the checker's count is stable.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, run without idling. Pop, remove and both picks on an empty
        // queue first, then the unused codes with all field bits low and high.
        send(make_cmd(ACT_POP, 8'd0, 16'd0, 8'd0));
        send(make_cmd(ACT_REMOVE, 8'd3, 16'd0, 8'd0));
        send(make_cmd(ACT_PICK_TIME, 8'd0, 16'd0, 8'd0));
        send(make_cmd(ACT_PICK_PRI, 8'd0, 16'd0, 8'd0));
        send(make_cmd(ACT_SPARE_LO, 8'd0, 16'd0, 8'd0));
        send(make_cmd(ACT_SPARE_HI, 8'hFF, 16'hFFFF, 8'hFF));

        // Five entries with extreme fields, a duplicate id, a time tie
        // between the second and fifth entry and a priority tie among the third,
        // fourth and fifth.
        send(make_cmd(ACT_PUSH, 8'd0, 16'hFFFF, 8'hFF));
        send(make_cmd(ACT_PUSH, 8'hFF, 16'd7, 8'hFF));
        send(make_cmd(ACT_PUSH, 8'd5, 16'd0, 8'd0));
        send(make_cmd(ACT_PUSH, 8'd5, 16'd20, 8'd0));
        send(make_cmd(ACT_PUSH, 8'd7, 16'd7, 8'd0));

        // Absent id, then the duplicate id where only the older copy goes.
        send(make_cmd(ACT_REMOVE, 8'd9, 16'd0, 8'd0));
        send(make_cmd(ACT_REMOVE, 8'd5, 16'd0, 8'd0));
        // Both picks resolve a tie in favor of the older entry.
        send(make_cmd(ACT_PICK_TIME, 8'd0, 16'd0, 8'd0));
        send(make_cmd(ACT_PICK_PRI, 8'd0, 16'd0, 8'd0));
        send(make_cmd(ACT_POP, 8'd0, 16'd0, 8'd0));
        // Clear with one entry left, then a pop must see an empty queue.
        send(make_cmd(ACT_CLEAR, 8'd0, 16'd0, 8'd0));
        send(make_cmd(ACT_POP, 8'd0, 16'd0, 8'd0));

        // Random part. Each phase starts from a quiet core, which is also
        // where the sender waits for every outstanding response.
        for (phase = 0; phase < 4; phase++)
        begin
            settle();
            idle_pct = PHASE_IDLE[phase];
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send(random_cmd(PUSH_WEIGHT[(n / SEGMENT_LEN) % 3]));
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0 && outstanding == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
